### hdl/cwp_pkg.sv
// Shared constants and types for the capacitive wheel position unit.
package cwp_pkg;

  // Field widths
  localparam int DELTA_BITS = 10;
  localparam int SUM_W      = DELTA_BITS + 2;
  localparam int GAIN_W     = 8;
  localparam int PROD_W     = DELTA_BITS + GAIN_W;
  localparam int ANGLE_W    = 8;
  localparam int STEP_W     = 16;

  // Stream word widths, padded to whole bytes
  localparam int IN_FIELDS_W  = 3 * DELTA_BITS + SUM_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_FIELDS_W = ANGLE_W + STEP_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_GAIN = 1'b0;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd83;

  // Sector bases and offset divisor
  localparam logic [ANGLE_W-1:0] BASE_A = 8'd0;
  localparam logic [ANGLE_W-1:0] BASE_B = 8'd86;
  localparam logic [ANGLE_W-1:0] BASE_C = 8'd171;
  localparam int OFFSET_DIV = 3;

  // Request to and response from the shared divider
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] num;
    logic [SUM_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quo;
  } div_rsp_t;

endpackage

### hdl/cwp_div.sv
// Shared restoring divider, one quotient bit per cycle.
module cwp_div import cwp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  rem_r;
  logic [SUM_W-1:0]  den_r;
  logic [PROD_W-1:0] quo_r;

  logic [SUM_W:0] shifted;
  logic [SUM_W:0] trial;
  logic           fits;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem_r, quo_r[PROD_W-1]};
    trial   = shifted - {1'b0, den_r};
    fits    = shifted >= {1'b0, den_r};
  end

  // Control: count the quotient bits, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(PROD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then shift in one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= fits ? trial[SUM_W-1:0] : shifted[SUM_W-1:0];
      quo_r <= {quo_r[PROD_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

### hdl/capacitive_wheel_position_unit.sv
// Top level: three-electrode wheel angle from a normalised centroid, with step count.
//
//  Channel  Ports                 Word contents (lowest bits first)
//  in       in_t* (slave)         tuser: touch_now, touch_before
//                                 tdata: delta_a, delta_b, delta_c, delta_sum
//  out      out_t* (master)       tuser: updated; tdata: wheel_angle, step_sum
//  cfg      psel..prdata (APB)    register 0 at address 0: gain
//
// A word without touch needs no division. A touch word runs one shared 18-bit
// restoring divider four times (three normalisations by the total, then the
// offset by three), one quotient bit per cycle, each run with its own set-up.
// Reset is synchronous and active low; gain returns to 83 and all angles and the
// step sum to zero. in_tready is high only while the sequencer is idle; a finished
// result waits in the output register until taken, a later one in the sequencer.
module capacitive_wheel_position_unit import cwp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // delta_a, delta_b, delta_c, delta_sum
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // touch_now, touch_before
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // wheel_angle, step_sum
  output logic                   out_tuser,  // updated
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DST  = 3'd2;
  localparam logic [2:0] ST_DWT  = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_OST  = 3'd5;
  localparam logic [2:0] ST_OWT  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [GAIN_W-1:0]     gain_r;
  logic [DELTA_BITS-1:0] dl_r [3];
  logic [SUM_W-1:0]      sum_r;
  logic                  before_r;
  logic [1:0]            ch_r;
  logic [PROD_W-1:0]     prod_r;
  logic [PROD_W-1:0]     q_r [3];
  logic [PROD_W-1:0]     mag_r;
  logic                  neg_r;
  logic [ANGLE_W-1:0]    base_r;
  logic                  upd_r;
  logic [ANGLE_W-1:0]    latest_r;
  logic [ANGLE_W-1:0]    shown_r;
  logic [STEP_W-1:0]     step_r;
  logic                  out_valid_r;
  logic                  out_upd_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               in_acc;
  logic               cfg_wr;
  logic               out_free;
  logic [PROD_W-1:0]  win_x, win_y;
  logic [ANGLE_W-1:0] win_base;
  logic [ANGLE_W-1:0] off8;
  logic [ANGLE_W-1:0] pos8;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Configuration port: register write and read back
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_GAIN) ? CFG_DATA_W'(gain_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_wr && (paddr[2] == REG_GAIN)) begin
      gain_r <= pwdata[GAIN_W-1:0];
    end
  end

  // Shared divider
  always_comb begin
    div_req.start = (state_r == ST_DST) || (state_r == ST_OST);
    div_req.num   = (state_r == ST_OST) ? mag_r : prod_r;
    div_req.den   = (state_r == ST_OST) ? SUM_W'(OFFSET_DIV) : sum_r;
  end

  cwp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sector choice: a if strictly largest, else b if no less than a and c, else c
  always_comb begin
    if ((q_r[0] > q_r[1]) && (q_r[0] > q_r[2])) begin
      win_base = BASE_A;
      win_x    = q_r[1];
      win_y    = q_r[2];
    end else if ((q_r[1] >= q_r[0]) && (q_r[1] >= q_r[2])) begin
      win_base = BASE_B;
      win_x    = q_r[2];
      win_y    = q_r[0];
    end else begin
      win_base = BASE_C;
      win_x    = q_r[0];
      win_y    = q_r[1];
    end
  end

  // Offset truncated toward zero: negate the magnitude quotient, keep low bits
  assign off8 = neg_r ? (ANGLE_W'(0) - div_rsp.quo[ANGLE_W-1:0])
                      : div_rsp.quo[ANGLE_W-1:0];
  assign pos8 = base_r + off8;

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = in_tuser[0] ? ST_MUL : ST_FIN;
      ST_MUL:  state_nxt = ST_DST;
      ST_DST:  state_nxt = ST_DWT;
      ST_DWT:  if (div_rsp.done) state_nxt = (ch_r == 2'd2) ? ST_CMP : ST_MUL;
      ST_CMP:  state_nxt = ST_OST;
      ST_OST:  state_nxt = ST_OWT;
      ST_OWT:  if (div_rsp.done) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and wheel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ch_r     <= '0;
      upd_r    <= 1'b0;
      latest_r <= '0;
      shown_r  <= '0;
      step_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        ch_r  <= '0;
        upd_r <= 1'b0;
      end
      if ((state_r == ST_DWT) && div_rsp.done) begin
        ch_r <= ch_r + 2'd1;
      end
      // Commit the new angle; on a repeated touch report it and count the step
      if ((state_r == ST_OWT) && div_rsp.done) begin
        latest_r <= pos8;
        if (before_r) begin
          upd_r   <= 1'b1;
          shown_r <= pos8;
          step_r  <= step_r + STEP_W'(pos8) - STEP_W'(latest_r);
        end
      end
    end
  end

  // Payload: capture the word, products, quotients and offset operands
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dl_r[0]  <= in_tdata[DELTA_BITS-1:0];
      dl_r[1]  <= in_tdata[2*DELTA_BITS-1:DELTA_BITS];
      dl_r[2]  <= in_tdata[3*DELTA_BITS-1:2*DELTA_BITS];
      sum_r    <= in_tdata[3*DELTA_BITS+SUM_W-1:3*DELTA_BITS];
      before_r <= in_tuser[1];
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(gain_r) * PROD_W'(dl_r[ch_r]);
    end
    // A zero total gives a zero quotient
    if ((state_r == ST_DWT) && div_rsp.done) begin
      q_r[ch_r] <= (sum_r == '0) ? '0 : div_rsp.quo;
    end
    if (state_r == ST_CMP) begin
      base_r <= win_base;
      neg_r  <= win_x < win_y;
      mag_r  <= (win_x < win_y) ? (win_y - win_x) : (win_x - win_y);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_FIN) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && out_free) begin
      out_upd_r  <= upd_r;
      out_data_r <= OUT_TDATA_W'({step_r, shown_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_upd_r;
  assign out_tdata  = out_data_r;

endmodule

### tb/sv/tb_capacitive_wheel_position_unit.sv
// Self-checking testbench for the capacitive wheel position unit: directed table, then random.
module tb_capacitive_wheel_position_unit import cwp_pkg::*; ();

  localparam int PAD_W        = IN_TDATA_W - IN_FIELDS_W;
  localparam int MAX_IDLE_RUN = 20;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_WORDS  = 490;
  localparam int DIR_ROWS     = 25;
  localparam int REG_SPARE    = 1;
  localparam bit PIN          = 1'b1;
  localparam bit CALC         = 1'b0;

  // One input word, fields in stream order
  typedef struct packed {
    logic                  touch_now;
    logic                  touch_before;
    logic [DELTA_BITS-1:0] delta_a;
    logic [DELTA_BITS-1:0] delta_b;
    logic [DELTA_BITS-1:0] delta_c;
    logic [SUM_W-1:0]      delta_sum;
    logic [PAD_W-1:0]      pad;
  } sample_t;

  localparam int SAMPLE_W = $bits(sample_t);

  // One result word
  typedef struct packed {
    logic                     updated;
    logic [ANGLE_W-1:0]       wheel_angle;
    logic signed [STEP_W-1:0] step_sum;
  } reading_t;

  typedef enum bit {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    sample_t     smp;
    bit          pinned;
    reading_t    want;
    int          reg_idx;
    logic [31:0] reg_value;
  } row_t;

  localparam sample_t  NO_SAMPLE = '0;
  localparam reading_t NO_WANT   = '0;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr = '0;
  logic [CFG_DATA_W-1:0]  pwdata = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  // Predictor state
  logic [GAIN_W-1:0]  wheel_gain = GAIN_RESET;
  logic [ANGLE_W-1:0] angle_latest = '0;
  logic [ANGLE_W-1:0] angle_prior = '0;
  logic [ANGLE_W-1:0] angle_shown = '0;
  logic [STEP_W-1:0]  step_acc = '0;

  reading_t expected_readings[$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int stall_run = 0;
  int cycle_count = 0;
  int words_sent = 0;
  int readings_checked = 0;
  int updates_seen = 0;
  int gain_writes = 0;
  int fail_count = 0;

  capacitive_wheel_position_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // delta_a, delta_b, delta_c, delta_sum
    .in_tuser   (in_tuser),   // touch_now, touch_before
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // wheel_angle, step_sum
    .out_tuser  (out_tuser),  // updated
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #6 clk = ~clk;

  // Advance the wheel state by one accepted word and return the reading it yields
  function automatic reading_t predict_reading(input sample_t s);
    int qa, qb, qc, pos;
    reading_t r;
    r.updated = 1'b0;
    if (s.touch_now) begin
      angle_prior = angle_latest;
      if (s.delta_sum == '0) begin
        qa = 0;
        qb = 0;
        qc = 0;
      end else begin
        qa = int'(wheel_gain) * int'(s.delta_a) / int'(s.delta_sum);
        qb = int'(wheel_gain) * int'(s.delta_b) / int'(s.delta_sum);
        qc = int'(wheel_gain) * int'(s.delta_c) / int'(s.delta_sum);
      end
      // a must beat both strictly; b wins ties against a and c
      if (qa > qb && qa > qc) begin
        pos = int'(BASE_A) + (qb - qc) / OFFSET_DIV;
      end else if (qb >= qa && qb >= qc) begin
        pos = int'(BASE_B) + (qc - qa) / OFFSET_DIV;
      end else begin
        pos = int'(BASE_C) + (qa - qb) / OFFSET_DIV;
      end
      angle_latest = ANGLE_W'(pos);
      if (s.touch_before) begin
        r.updated   = 1'b1;
        angle_shown = angle_latest;
        step_acc    = step_acc + STEP_W'(angle_shown) - STEP_W'(angle_prior);
      end
    end
    r.wheel_angle = angle_shown;
    r.step_sum    = step_acc;
    return r;
  endfunction

  // Offer one word after a random gap, hold it until taken, then log its reading
  task automatic send_word(input sample_t s, input bit pinned, input reading_t want);
    reading_t calc;
    int idle_run;
    idle_run = 0;
    while (idle_run < MAX_IDLE_RUN && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      idle_run++;
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {s.pad, s.delta_sum, s.delta_c, s.delta_b, s.delta_a};
    in_tuser  <= {s.touch_before, s.touch_now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    calc = predict_reading(s);
    expected_readings.push_back(pinned ? want : calc);
    words_sent++;
  endtask

  // Write a register once the unit has drained, then read the gain back
  task automatic write_reg(input int idx, input logic [31:0] value);
    in_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == int'(REG_GAIN)) begin
      wheel_gain = value[GAIN_W-1:0];
      gain_writes++;
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(int'(REG_GAIN) * 4);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== CFG_DATA_W'(wheel_gain)) begin
      $error("gain: expected %0d, got %0d", wheel_gain, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Touch word with plausible deltas; the total is usually their sum
  function automatic sample_t touch_sample(input bit now, input bit prev);
    sample_t s;
    int pick;
    s = NO_SAMPLE;
    s.touch_now    = now;
    s.touch_before = prev;
    s.delta_a      = DELTA_BITS'($urandom_range(1023));
    s.delta_b      = DELTA_BITS'($urandom_range(1023));
    s.delta_c      = DELTA_BITS'($urandom_range(1023));
    pick = $urandom_range(99);
    if (pick < 80) begin
      s.delta_sum = SUM_W'(int'(s.delta_a) + int'(s.delta_b) + int'(s.delta_c));
    end else if (pick < 90) begin
      s.delta_sum = SUM_W'($urandom_range(4095));
    end else if (pick < 95) begin
      s.delta_sum = '0;
    end else begin
      s.delta_sum = SUM_W'($urandom_range(1, 15));
    end
    return s;
  endfunction

  // Random part: strokes, climbing pairs that push the step sum round, and noise
  task automatic random_words(input int count);
    sample_t s;
    int sent, len, pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        // stroke: first touch, held touches, release
        len = $urandom_range(2, 8);
        for (int k = 0; k < len && sent < count; k++) begin
          if (k == 0) begin
            s = touch_sample(1'b1, $urandom_range(99) < 10);
          end else if (k == len - 1) begin
            s = touch_sample(1'b0, 1'b1);
          end else begin
            s = touch_sample(1'b1, 1'b1);
          end
          send_word(s, CALC, NO_WANT);
          sent++;
        end
      end else if (pick < 75) begin
        // climb: land near zero unreported, then report an angle just below a turn
        s = NO_SAMPLE;
        s.touch_now = 1'b1;
        s.delta_a   = DELTA_BITS'(1023);
        s.delta_sum = SUM_W'(1023);
        send_word(s, CALC, NO_WANT);
        s.touch_before = 1'b1;
        s.delta_c      = DELTA_BITS'($urandom_range(1, 120));
        send_word(s, CALC, NO_WANT);
        sent += 2;
      end else begin
        // noise: every bit random, pad included
        len = $urandom_range(1, 3);
        for (int k = 0; k < len && sent < count; k++) begin
          s = SAMPLE_W'({$urandom(), $urandom()});
          send_word(s, CALC, NO_WANT);
          sent++;
        end
      end
    end
  endtask

  // Receiver: stall at random, compare each taken word with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_run = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected result word: updated %0d, wheel_angle %0d, step_sum %0d",
                 out_tuser, out_tdata[ANGLE_W-1:0], $signed(out_tdata[ANGLE_W +: STEP_W]));
          fail_count++;
        end else begin
          reading_t want;
          want = expected_readings.pop_front();
          if (out_tuser !== want.updated) begin
            $error("updated: expected %0d, got %0d", want.updated, out_tuser);
            fail_count++;
          end
          if (out_tdata[ANGLE_W-1:0] !== want.wheel_angle) begin
            $error("wheel_angle: expected %0d, got %0d", want.wheel_angle,
                   out_tdata[ANGLE_W-1:0]);
            fail_count++;
          end
          if (out_tdata[ANGLE_W +: STEP_W] !== want.step_sum) begin
            $error("step_sum: expected %0d, got %0d", want.step_sum,
                   $signed(out_tdata[ANGLE_W +: STEP_W]));
            fail_count++;
          end
          if (out_tuser === 1'b1) updates_seen++;
          readings_checked++;
        end
      end
      if (stall_run < MAX_IDLE_RUN && $urandom_range(99) < rx_stall_pct) begin
        out_tready <= 1'b0;
        stall_run++;
      end else begin
        out_tready <= 1'b1;
        stall_run = 0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_readings.size());
      $display("capacitive_wheel_position_unit: mismatch");
      $finish;
    end
  end

  initial begin
    row_t rows [DIR_ROWS];
    int   phase_gain [4];
    rows = '{
      // no touch straight after reset, then with every delta, total and pad at its top
      '{ROW_WORD, '{1'b0, 1'b0, 10'd0, 10'd0, 10'd0, 12'd0, 6'd0},
        PIN, '{1'b0, 8'd0, 16'sd0}, 0, 32'd0},
      '{ROW_WORD, '{1'b0, 1'b1, 10'd1023, 10'd1023, 10'd1023, 12'd4095, 6'h3F},
        PIN, '{1'b0, 8'd0, 16'sd0}, 0, 32'd0},
      // first touch on a zero total: angle latched but not shown
      '{ROW_WORD, '{1'b1, 1'b0, 10'd0, 10'd0, 10'd0, 12'd0, 6'd0},
        PIN, '{1'b0, 8'd0, 16'sd0}, 0, 32'd0},
      '{ROW_WORD, '{1'b1, 1'b1, 10'd0, 10'd0, 10'd0, 12'd0, 6'd0},
        PIN, '{1'b1, 8'd86, 16'sd0}, 0, 32'd0},
      // one electrode alone gives each sector base
      '{ROW_WORD, '{1'b1, 1'b1, 10'd1023, 10'd0, 10'd0, 12'd1023, 6'd0},
        PIN, '{1'b1, 8'd0, 16'hFFAA}, 0, 32'd0},
      '{ROW_WORD, '{1'b1, 1'b1, 10'd0, 10'd1023, 10'd0, 12'd1023, 6'd0},
        PIN, '{1'b1, 8'd86, 16'sd0}, 0, 32'd0},
      '{ROW_WORD, '{1'b1, 1'b1, 10'd0, 10'd0, 10'd1023, 12'd1023, 6'd0},
        PIN, '{1'b1, 8'd171, 16'sd85}, 0, 32'd0},
      // negative offset wraps below zero
      '{ROW_WORD, '{1'b1, 1'b1, 10'd1023, 10'd0, 10'd900, 12'd1023, 6'd0},
        CALC, NO_WANT, 0, 32'd0},
      // deltas far above the total, then far below it: a three-way tie each time
      '{ROW_WORD, '{1'b1, 1'b1, 10'd1023, 10'd1023, 10'd1023, 12'd1, 6'd0},
        CALC, NO_WANT, 0, 32'd0},
      '{ROW_WORD, '{1'b1, 1'b1, 10'd5, 10'd3, 10'd1, 12'd4095, 6'd0},
        CALC, NO_WANT, 0, 32'd0},
      // a level with b, then a level with c
      '{ROW_WORD, '{1'b1, 1'b1, 10'd700, 10'd700, 10'd100, 12'd1500, 6'd0},
        CALC, NO_WANT, 0, 32'd0},
      '{ROW_WORD, '{1'b1, 1'b1, 10'd800, 10'd100, 10'd800, 12'd1700, 6'd0},
        CALC, NO_WANT, 0, 32'd0},
      '{ROW_WORD, '{1'b1, 1'b1, 10'd100, 10'd900, 10'd300, 12'd1300, 6'd0},
        CALC, NO_WANT, 0, 32'd0},
      '{ROW_WORD, '{1'b1, 1'b1, 10'd1023, 10'd600, 10'd0, 12'd1623, 6'd0},
        CALC, NO_WANT, 0, 32'd0},
      // top gain
      '{ROW_REG, NO_SAMPLE, CALC, NO_WANT, int'(REG_GAIN), 32'd255},
      '{ROW_WORD, '{1'b1, 1'b1, 10'd1023, 10'd0, 10'd512, 12'd1535, 6'd0},
        CALC, NO_WANT, 0, 32'd0},
      '{ROW_WORD, '{1'b1, 1'b1, 10'd0, 10'd1023, 10'd1023, 12'd1, 6'd0},
        CALC, NO_WANT, 0, 32'd0},
      // zero gain flattens everything onto sector b
      '{ROW_REG, NO_SAMPLE, CALC, NO_WANT, int'(REG_GAIN), 32'd0},
      '{ROW_WORD, '{1'b1, 1'b1, 10'd1023, 10'd0, 10'd0, 12'd1023, 6'd0},
        CALC, NO_WANT, 0, 32'd0},
      // write to an unmapped register must leave the gain alone
      '{ROW_REG, NO_SAMPLE, CALC, NO_WANT, REG_SPARE, 32'hFFFF_FFFF},
      '{ROW_WORD, '{1'b1, 1'b1, 10'd0, 10'd0, 10'd1023, 12'd1023, 6'd0},
        CALC, NO_WANT, 0, 32'd0},
      // upper data bits of the write are dropped
      '{ROW_REG, NO_SAMPLE, CALC, NO_WANT, int'(REG_GAIN), 32'hFFFF_FF53},
      '{ROW_WORD, '{1'b1, 1'b0, 10'd300, 10'd200, 10'd100, 12'd600, 6'd0},
        CALC, NO_WANT, 0, 32'd0},
      '{ROW_WORD, '{1'b1, 1'b1, 10'd1023, 10'd1023, 10'd1023, 12'd4095, 6'h3F},
        CALC, NO_WANT, 0, 32'd0},
      '{ROW_WORD, '{1'b0, 1'b0, 10'd1023, 10'd512, 10'd1, 12'd2048, 6'h3F},
        CALC, NO_WANT, 0, 32'd0}
    };
    phase_gain = '{255, 1, $urandom_range(2, 254), int'(GAIN_RESET)};

    // Hold reset, then release it
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, no idling
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        write_reg(rows[i].reg_idx, rows[i].reg_value);
      end else begin
        send_word(rows[i].smp, rows[i].pinned, rows[i].want);
      end
    end

    // Random phases: free flow, idle sender, stalling receiver, both
    for (int p = 0; p < 4; p++) begin
      write_reg(int'(REG_GAIN), 32'(phase_gain[p]));
      tx_idle_pct  = (p == 1) ? 83 : (p == 3) ? 31 : 0;
      rx_stall_pct = (p == 2) ? 83 : (p == 3) ? 31 : 0;
      random_words(PHASE_WORDS);
    end

    // Drain, then allow for one more touch computation
    in_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words sent over 4 handshake phases and %0d gain settings",
             words_sent, gain_writes);
    $display("%0d results checked, %0d position updates, final step sum %0d",
             readings_checked, updates_seen, $signed(step_acc));
    if (fail_count == 0) begin
      $display("capacitive_wheel_position_unit: match");
    end else begin
      $display("capacitive_wheel_position_unit: mismatch");
    end
    $finish;
  end

endmodule

### files.f
hdl/cwp_pkg.sv
hdl/cwp_div.sv
hdl/capacitive_wheel_position_unit.sv
tb/sv/tb_capacitive_wheel_position_unit.sv
